// File: rtl/fmrb_pkg.sv
// Shared types, widths and codes of the framed message ring buffer.
package fmrb_pkg;

    localparam int OP_W      = 2;
    localparam int LEN_W     = 12;
    localparam int FLOW_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int ST_W      = 3;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    localparam int RING_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int CMD_DEPTH_DEF    = 2;

    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_WDATA   = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQ_HDR = 2'd2;
    localparam logic [OP_W-1:0] OP_RDATA   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [ST_W-1:0] ST_TOOLONG = 3'd3;
    localparam logic [ST_W-1:0] ST_SEQ     = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   kind;
        logic [LEN_W-1:0]  msg_len;
        logic [FLOW_W-1:0] flow;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  max_len;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              was_empty;
        logic [LEN_W-1:0]  length;
        logic [FLOW_W-1:0] flow_out;
        logic [BYTE_W-1:0] data_out;
        logic              last_byte;
    } t_result;

endpackage

// File: rtl/framed_message_ring_buffer.sv
// Framed message ring buffer top level: input queue, ring executor and byte RAM.
// Each item yields exactly one result item, in order. Items first pass a short
// command queue, then an executor that owns the byte ring memory (one write and
// one registered read per cycle). An enqueue data byte is written at once, a read
// payload byte comes through the registered RAM read, an accepted start enqueue
// writes its HEADER_BYTES header bytes one per cycle, and a dequeue header that
// finds a message issues the read, reads the eight header bytes one per
// cycle behind the registered RAM read and then checks the length; refused
// or out-of-sequence items are answered from idle without touching the ring.
// Results wait in an output register while the command queue fills.
module framed_message_ring_buffer
    import fmrb_pkg::*;
#(
    parameter int RING_BYTES   = RING_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int CMD_DEPTH    = CMD_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // msg_len, flow, data_byte, max_len
    input  logic [OP_W-1:0]      i_s_tuser,  // operation
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // was_empty, length, flow_out, data_out, zero pad
    output logic [ST_W-1:0]      o_m_tuser,  // status
    output logic                 o_m_tlast   // last_byte
);

    localparam int PW = $clog2(RING_BYTES);

    logic              w_cmd_valid;
    t_cmd              w_cmd;
    logic              w_cmd_pop;
    logic              w_we;
    logic [PW-1:0]     w_waddr;
    logic [BYTE_W-1:0] w_wdata;
    logic [PW-1:0]     w_raddr;
    logic [BYTE_W-1:0] w_rdata;
    t_result           w_res;

    fmrb_front #(
        .CMD_DEPTH(CMD_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    fmrb_back #(
        .RING_BYTES  (RING_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata),
        .o_res_valid(o_m_tvalid),
        .i_res_ready(i_m_tready),
        .o_res      (w_res)
    );

    fmrb_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(RING_BYTES)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_m_tdata = {3'b000, w_res.data_out, w_res.flow_out, w_res.length, w_res.was_empty};
    assign o_m_tuser = w_res.status;
    assign o_m_tlast = w_res.last_byte;

endmodule

// File: rtl/fmrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fmrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fmrb_front.sv
// Front end: accepts input items, unpacks them into commands and queues them.
module fmrb_front
    import fmrb_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [OP_W-1:0]      i_s_tuser,
    output logic                 o_cmd_valid,
    output t_cmd                 o_cmd,
    input  logic                 i_cmd_pop
);

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(CMD_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(CMD_DEPTH - 1);

    t_cmd             r_q [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_cmd             w_cmd;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        w_cmd.kind      = i_s_tuser;
        w_cmd.msg_len   = i_s_tdata[11:0];
        w_cmd.flow      = i_s_tdata[43:12];
        w_cmd.data_byte = i_s_tdata[51:44];
        w_cmd.max_len   = i_s_tdata[63:52];
    end

    assign o_s_tready  = (r_count != DEPTH_C);
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_P) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_P) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// File: rtl/fmrb_back.sv
// Back end: runs queued commands against the byte ring and registers the result.
module fmrb_back
    import fmrb_pkg::*;
#(
    parameter int RING_BYTES   = RING_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  t_cmd                          i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_we,
    output logic [$clog2(RING_BYTES)-1:0] o_waddr,
    output logic [BYTE_W-1:0]             o_wdata,
    output logic [$clog2(RING_BYTES)-1:0] o_raddr,
    input  logic [BYTE_W-1:0]             i_rdata,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output t_result                       o_res
);

    localparam int PW   = $clog2(RING_BYTES);
    localparam int CW   = $clog2(HEADER_BYTES + 1);
    localparam logic [PW:0]   RING_W   = (PW+1)'(RING_BYTES);
    localparam logic [PW:0]   HDR_W    = (PW+1)'(HEADER_BYTES);
    localparam logic [CW-1:0] HDR_LAST = CW'(HEADER_BYTES - 1);
    localparam logic [CW-1:0] RD_LAST  = CW'(8);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HWR  = 3'd1;
    localparam logic [2:0] S_HRD  = 3'd2;
    localparam logic [2:0] S_HFIN = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [PW-1:0]    r_rd_pos, n_rd_pos;
    logic [PW-1:0]    r_tail, n_tail;
    logic [PW-1:0]    r_wr_pos, n_wr_pos;
    logic [LEN_W-1:0] r_wr_rem, n_wr_rem;
    logic [LEN_W-1:0] r_rd_rem, n_rd_rem;
    logic             r_wr_open, n_wr_open;
    logic             r_res_valid, n_res_valid;
    logic [PW-1:0]    r_addr, n_addr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [63:0]      r_hdr, n_hdr;
    logic [LEN_W-1:0] r_max_len, n_max_len;
    t_result          r_res, n_res;

    logic             w_res_free;
    logic             w_emit;
    t_result          w_res;
    logic [PW:0]      w_free;
    logic [31:0]      w_total;
    logic [31:0]      w_plen;

    function automatic logic [PW-1:0] f_add(input logic [PW-1:0] p, input logic [PW:0] n);
        logic [PW:0] s;
        s = {1'b0, p} + n;
        if (s >= RING_W) begin
            s = s - RING_W;
        end
        return s[PW-1:0];
    endfunction

    assign w_res_free = !r_res_valid || i_res_ready;
    assign w_free     = (r_rd_pos > r_tail) ? ({1'b0, r_rd_pos} - {1'b0, r_tail})
                                            : ({1'b0, r_rd_pos} + RING_W - {1'b0, r_tail});
    assign w_total    = 32'(i_cmd.msg_len) + 32'(HEADER_BYTES);
    assign w_plen     = r_hdr[31:0] - 32'(HEADER_BYTES);

    always_comb begin
        n_state     = r_state;
        n_rd_pos    = r_rd_pos;
        n_tail      = r_tail;
        n_wr_pos    = r_wr_pos;
        n_wr_rem    = r_wr_rem;
        n_rd_rem    = r_rd_rem;
        n_wr_open   = r_wr_open;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_hdr       = r_hdr;
        n_max_len   = r_max_len;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;
        o_cmd_pop   = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_addr;
        o_wdata     = '0;
        o_raddr     = r_addr;
        w_emit      = 1'b0;
        w_res       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_res_free) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        OP_START: begin
                            w_emit = 1'b1;
                            if (r_wr_open) begin
                                w_res.status = ST_SEQ;
                            end else if (32'(w_free) <= w_total) begin
                                w_res.status = ST_NOSPACE;
                            end else begin
                                w_res.status    = ST_OK;
                                w_res.was_empty = (w_free == RING_W);
                                n_hdr           = {i_cmd.flow, w_total};
                                n_addr          = r_tail;
                                n_cnt           = '0;
                                n_state         = S_HWR;
                                n_wr_pos        = f_add(r_tail, HDR_W);
                                n_wr_rem        = i_cmd.msg_len;
                                if (i_cmd.msg_len == '0) begin
                                    n_tail          = f_add(r_tail, HDR_W);
                                    w_res.last_byte = 1'b1;
                                end else begin
                                    n_wr_open = 1'b1;
                                end
                            end
                        end
                        OP_WDATA: begin
                            w_emit = 1'b1;
                            if (!r_wr_open) begin
                                w_res.status = ST_SEQ;
                            end else begin
                                o_we     = 1'b1;
                                o_waddr  = r_wr_pos;
                                o_wdata  = i_cmd.data_byte;
                                n_wr_pos = f_add(r_wr_pos, (PW+1)'(1));
                                n_wr_rem = r_wr_rem - 1'b1;
                                if (r_wr_rem == LEN_W'(1)) begin
                                    n_tail          = f_add(r_wr_pos, (PW+1)'(1));
                                    n_wr_open       = 1'b0;
                                    w_res.last_byte = 1'b1;
                                end
                            end
                        end
                        OP_DEQ_HDR: begin
                            if (r_rd_rem != '0) begin
                                w_emit       = 1'b1;
                                w_res.status = ST_SEQ;
                            end else if (r_rd_pos == r_tail) begin
                                w_emit       = 1'b1;
                                w_res.status = ST_EMPTY;
                            end else begin
                                n_addr    = r_rd_pos;
                                n_cnt     = '0;
                                n_max_len = i_cmd.max_len;
                                n_state   = S_HRD;
                            end
                        end
                        OP_RDATA: begin
                            if (r_rd_rem == '0) begin
                                w_emit       = 1'b1;
                                w_res.status = ST_SEQ;
                            end else begin
                                o_raddr = r_rd_pos;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            w_emit       = 1'b1;
                            w_res.status = ST_SEQ;
                        end
                    endcase
                end
            end
            S_HWR: begin
                o_we    = 1'b1;
                o_waddr = r_addr;
                if (r_cnt < CW'(8)) begin
                    o_wdata = r_hdr[{r_cnt[2:0], 3'b000} +: 8];
                end
                n_addr = f_add(r_addr, (PW+1)'(1));
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == HDR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_HRD: begin
                o_raddr = r_addr;
                if (r_cnt != '0) begin
                    n_hdr = {i_rdata, r_hdr[63:8]};
                end
                n_addr = f_add(r_addr, (PW+1)'(1));
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == RD_LAST) begin
                    n_state = S_HFIN;
                end
            end
            S_HFIN: begin
                w_emit         = 1'b1;
                w_res.length   = w_plen[LEN_W-1:0];
                w_res.flow_out = r_hdr[63:32];
                if (w_plen > 32'(r_max_len)) begin
                    w_res.status = ST_TOOLONG;
                end else begin
                    w_res.status = ST_OK;
                    n_rd_pos     = f_add(r_rd_pos, HDR_W);
                    n_rd_rem     = w_plen[LEN_W-1:0];
                end
                n_state = S_IDLE;
            end
            S_RD: begin
                w_emit          = 1'b1;
                w_res.status    = ST_OK;
                w_res.data_out  = i_rdata;
                w_res.last_byte = (r_rd_rem == LEN_W'(1));
                n_rd_pos        = f_add(r_rd_pos, (PW+1)'(1));
                n_rd_rem        = r_rd_rem - 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_emit) begin
            n_res_valid = 1'b1;
            n_res       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pos    <= '0;
            r_tail      <= '0;
            r_wr_pos    <= '0;
            r_wr_rem    <= '0;
            r_rd_rem    <= '0;
            r_wr_open   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pos    <= n_rd_pos;
            r_tail      <= n_tail;
            r_wr_pos    <= n_wr_pos;
            r_wr_rem    <= n_wr_rem;
            r_rd_rem    <= n_rd_rem;
            r_wr_open   <= n_wr_open;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_cnt     <= n_cnt;
        r_hdr     <= n_hdr;
        r_max_len <= n_max_len;
        r_res     <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// File: rtl/fmrb_checker.sv
// Port-level checks of the framed message ring buffer and their binding.
module fmrb_checker
    import fmrb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [ST_W-1:0]      o_m_tuser,
    input logic                 o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser <= ST_SEQ)
        else $error("status code out of range");

    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser == ST_OK)
        else $error("last byte flagged on a refused item");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_OK |-> o_m_tdata[0] == 1'b0
            && o_m_tdata[52:45] == 8'd0)
        else $error("refused item carries data");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_EMPTY |-> o_m_tdata[12:1] == 12'd0)
        else $error("empty result carries a length");

endmodule

bind framed_message_ring_buffer fmrb_checker u_fmrb_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser),
    .o_m_tlast (o_m_tlast)
);
